// ===== rtl/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared constants and types of the causal convolution MAC.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int TAP_AW      = $clog2(MAX_TAPS);
    localparam int CNT_W       = TAP_AW + 1;
    localparam int KLEN_W      = 11;
    localparam int KLEN_RESET  = 1024;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int Y_BITS      = 42;
    localparam int APB_AW      = 2;
    localparam int APB_DW      = 32;
    localparam int S_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((Y_BITS + 7) / 8) * 8;

    // sequencer to datapath
    typedef struct packed {
        logic clr;     // clear accumulator, new request
        logic rd_vld;  // RAM read data valid this cycle
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/causal_convolution_mac.sv =====
// ----------------------------------------------------------------------------
// causal_convolution_mac
// Causal linear convolution of a sample stream with a kernel taken from the
// first kernel_length r samples, one shared MAC walking two sample RAMs.
// Each accepted request walks taps = min(index+1, kernel_length) taps, where
//   index = position in the signal; the next request is taken only once the
//   result has moved to the output register. The walk uses the single MAC,
//   reading one kernel tap and one history sample per cycle.
// Reset: rst_n async; clears sequencer, counters, output valid, and sets
//   kernel_length to 1024. RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module causal_convolution_mac
    import ccm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready,
    // sample requests
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [15:0] s_sample, [31:16] r_sample
    input  wire logic                 s_tlast,  // last
    // results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,  // [41:0] y_sum, rest zero
    output logic                      m_tlast   // end_of_signal
);

    // ---------------- configuration register ----------------
    // Single register: every word address decodes to kernel_length.
    logic [KLEN_W-1:0] kernel_length_reg;

    assign pready = 1'b1;
    assign prdata = APB_DW'(kernel_length_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_length_reg <= KLEN_W'(KLEN_RESET);
        end
        else if (psel && penable && pwrite && pready)
        begin
            kernel_length_reg <= pwdata[KLEN_W-1:0];
        end
    end

    // ---------------- input unpack ----------------
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          accept;

    assign s_sample = s_tdata[SAMPLE_BITS-1:0];
    assign r_sample = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // ---------------- sequencer ----------------
    logic              idle;
    logic              ker_we;
    logic              ring_we;
    logic [TAP_AW-1:0] ker_waddr;
    logic [TAP_AW-1:0] ring_waddr;
    logic [TAP_AW-1:0] ker_raddr;
    logic [TAP_AW-1:0] ring_raddr;
    mac_ctl_t          mac_ctl;
    logic              finish;
    logic              fin_last;
    logic              out_free;
    logic              m_tvalid_reg;

    // One request in flight; the output register frees the engine so the
    // next request can come in while a result waits downstream.
    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    ccm_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_last       (s_tlast),
        .kernel_length (kernel_length_reg),
        .out_free      (out_free),
        .idle          (idle),
        .ker_we        (ker_we),
        .ker_waddr     (ker_waddr),
        .ring_we       (ring_we),
        .ring_waddr    (ring_waddr),
        .ker_raddr     (ker_raddr),
        .ring_raddr    (ring_raddr),
        .mac_ctl       (mac_ctl),
        .finish        (finish),
        .fin_last      (fin_last)
    );

    // ---------------- sample memories ----------------
    // Writes land on the accept edge; reads start the cycle after, so the
    // tap just written is already visible to the walk.
    logic [SAMPLE_BITS-1:0] ker_q;
    logic [SAMPLE_BITS-1:0] ring_q;

    ccm_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_BITS)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (ker_we),
        .waddr (ker_waddr),
        .wdata (r_sample),
        .raddr (ker_raddr),
        .rdata (ker_q)
    );

    ccm_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (SAMPLE_BITS)
    ) u_history_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (s_sample),
        .raddr (ring_raddr),
        .rdata (ring_q)
    );

    // ---------------- MAC ----------------
    logic signed [Y_BITS-1:0] acc;

    ccm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .ker_q  (ker_q),
        .ring_q (ring_q),
        .acc    (acc)
    );

    // ---------------- output register ----------------
    logic [Y_BITS-1:0]    y_sum_reg;
    logic                 m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            y_sum_reg   <= acc;
            m_tlast_reg <= fin_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(y_sum_reg);
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ===== rtl/ccm_ram.sv =====
// ----------------------------------------------------------------------------
// ccm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ccm_mac.sv =====
// ----------------------------------------------------------------------------
// ccm_mac
// Multiply-accumulate datapath: registered product, wrapping accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_mac
    import ccm_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mac_ctl_t                      ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] ker_q,
    input  wire logic signed [SAMPLE_BITS-1:0] ring_q,
    output logic signed      [Y_BITS-1:0]      acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [Y_BITS-1:0] acc_reg;
    logic signed [Y_BITS-1:0] acc_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= ker_q * ring_q;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + Y_BITS'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.rd_vld;
            acc_reg      <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/ccm_seq.sv =====
// ----------------------------------------------------------------------------
// ccm_seq
// Tap sequencer: memory writes per request, read address walk, drain, finish.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_seq
    import ccm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              in_last,
    input  wire logic [KLEN_W-1:0] kernel_length,
    input  wire logic              out_free,
    output logic                   idle,
    output logic                   ker_we,
    output logic [TAP_AW-1:0]      ker_waddr,
    output logic                   ring_we,
    output logic [TAP_AW-1:0]      ring_waddr,
    output logic [TAP_AW-1:0]      ker_raddr,
    output logic [TAP_AW-1:0]      ring_raddr,
    output mac_ctl_t               mac_ctl,
    output logic                   finish,
    output logic                   fin_last
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;   // sample index, saturating
    logic [TAP_AW-1:0] wp_reg, wp_next;         // ring slot for next sample
    logic [TAP_AW-1:0] cur_wp_reg, cur_wp_next;
    logic [CNT_W-1:0]  taps_reg, taps_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              drain_reg, drain_next;
    logic              last_reg, last_next;
    logic              rd_vld_reg;
    logic [CNT_W-1:0]  klen;
    logic [CNT_W-1:0]  count_inc;
    logic              issue;

    // lengths above the store depth use the whole store
    assign klen = (CNT_W'(kernel_length) > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                              : CNT_W'(kernel_length);
    assign count_inc = count_reg + CNT_W'(1);

    assign issue      = (state_reg == ST_RUN);
    assign idle       = (state_reg == ST_IDLE);
    assign ker_we     = accept && (count_reg < klen);
    assign ker_waddr  = count_reg[TAP_AW-1:0];
    assign ring_we    = accept;
    assign ring_waddr = wp_reg;
    assign ker_raddr  = k_reg[TAP_AW-1:0];
    assign ring_raddr = cur_wp_reg - k_reg[TAP_AW-1:0];
    assign finish     = (state_reg == ST_FINISH) && out_free;
    assign fin_last   = last_reg;

    assign mac_ctl.clr    = accept;
    assign mac_ctl.rd_vld = rd_vld_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        wp_next     = wp_reg;
        cur_wp_next = cur_wp_reg;
        taps_next   = taps_reg;
        k_next      = k_reg;
        drain_next  = drain_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cur_wp_next = wp_reg;
                    last_next   = in_last;
                    k_next      = '0;
                    drain_next  = 1'b0;
                    taps_next   = (count_inc > klen) ? klen : count_inc;
                    state_next  = (klen == '0) ? ST_DRAIN : ST_RUN;
                    if (in_last)
                    begin
                        wp_next    = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        wp_next = wp_reg + TAP_AW'(1);
                        if (count_reg < CNT_W'(MAX_TAPS))
                        begin
                            count_next = count_inc;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg == taps_reg - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // read data, then product, then accumulator
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            wp_reg     <= '0;
            drain_reg  <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            wp_reg     <= wp_next;
            drain_reg  <= drain_next;
            rd_vld_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_wp_reg <= cur_wp_next;
        taps_reg   <= taps_next;
        k_reg      <= k_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/ccm_checker.sv =====
// ----------------------------------------------------------------------------
// ccm_checker
// Port-level checks of the causal convolution MAC, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_checker
    import ccm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 psel,
    input wire logic                 pready,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    logic [1:0] pend_reg;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // requests accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(s_acc) - 2'(m_acc);
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // one request at a time in the engine
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("second request taken while busy");

    // no result without an outstanding request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without request");

    // at most one finished result waiting plus one in work
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests outstanding");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("config port stalled");

endmodule

bind causal_convolution_mac ccm_checker u_ccm_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for causal_convolution_mac: streams sample pairs, runs a
// convolution predictor on every accepted request and compares
// each result in order; kernel_length is reprogrammed over the APB port
// between phases, including once in the middle of a signal.
// ----------------------------------------------------------------------------

module tb_top;
    import ccm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // register map
    localparam logic [APB_AW-1:0] KLEN_ADDR = '0;

    // run shape
    localparam int RANDOM_REQS = 555;    // short-signal requests after the directed part
    localparam int HOLD_CYCLES = 400;    // single long sink hold-off
    localparam int CYCLE_LIMIT = 1000000;

    // one request: a sample of each signal plus end-of-signal mark
    typedef struct {
        logic [SAMPLE_BITS-1:0] s_sample;
        logic [SAMPLE_BITS-1:0] r_sample;
        logic                   last;
    } conv_req_t;

    typedef struct {
        logic [Y_BITS-1:0] y_sum;
        logic              end_of_signal;
    } conv_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [15:0] s_sample, [31:16] r_sample
    logic                 s_tlast  = 1'b0;  // last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [41:0] y_sum, rest zero
    logic                 m_tlast;          // end_of_signal

    causal_convolution_mac dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Convolution predictor state (own copy of kernel, history and counters)
    // ------------------------------------------------------------------------
    bit signed [SAMPLE_BITS-1:0] kernel_taps [MAX_TAPS] = '{default: '0};
    bit signed [SAMPLE_BITS-1:0] sample_hist [MAX_TAPS] = '{default: '0};
    logic [TAP_AW-1:0]           hist_ptr    = '0;
    int unsigned                 sig_index   = 0;      // saturates at MAX_TAPS
    logic [KLEN_W-1:0]           klen_model  = KLEN_W'(KLEN_RESET);

    conv_req_t    pending_reqs [$];   // requests not yet offered
    conv_result_t y_expected [$];     // predicted results, oldest first
    conv_result_t oldest_y;
    conv_req_t    queued_req;

    int  gap_left    = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;          // phase with no idling on either side
    bit  hold_req    = 1'b0;          // ask the sink for its long hold-off
    bit  hold_done   = 1'b0;
    int  mismatches  = 0;
    int  cfg_errors  = 0;

    // y[i] = sum r[k]*s[i-k], k < min(i+1, kernel length); updates state as
    // the block does on acceptance and queues the expected result
    function automatic void convolve_request(logic signed [SAMPLE_BITS-1:0] s,
                                             logic signed [SAMPLE_BITS-1:0] r,
                                             logic last);
        int unsigned  eff_len;
        int unsigned  taps;
        int unsigned  idx;
        longint       acc;
        conv_result_t res;

        eff_len = (klen_model > MAX_TAPS) ? MAX_TAPS : klen_model;  // oversize clamps
        if (sig_index < eff_len)
            kernel_taps[sig_index] = r;                             // later r ignored
        sample_hist[hist_ptr] = s;

        taps = (sig_index + 1 > eff_len) ? eff_len : sig_index + 1;  // zero length: no taps
        idx  = hist_ptr;
        acc  = 0;
        for (int k = 0; k < taps; k++)
        begin
            acc += longint'(kernel_taps[k]) * longint'(sample_hist[idx]);
            idx  = (idx == 0) ? MAX_TAPS - 1 : idx - 1;
        end

        if (last)
        begin
            hist_ptr  = '0;
            sig_index = 0;
        end
        else
        begin
            hist_ptr = hist_ptr + 1'b1;
            if (sig_index < MAX_TAPS)
                sig_index++;
        end

        res.y_sum         = acc[Y_BITS-1:0];
        res.end_of_signal = last;
        y_expected.push_back(res);
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: offers queued requests, predicts on each handshake
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                convolve_request(s_tdata[SAMPLE_BITS-1:0],
                                 s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], s_tlast);

            // valid only moves once the current request is taken
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    queued_req = pending_reqs.pop_front();
                    s_tdata  <= {queued_req.r_sample, queued_req.s_sample};
                    s_tlast  <= queued_req.last;
                    s_tvalid <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink ready: random stalls, plus one long hold-off to back up the block
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end

            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (calm || $urandom_range(0, 99) < 70)
                m_tready <= 1'b1;
            else
            begin
                m_tready   <= 1'b0;
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: in-order compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (y_expected.size() == 0)
            begin
                $error("unexpected result: y_sum %0d end_of_signal %0b",
                       $signed(m_tdata[Y_BITS-1:0]), m_tlast);
                mismatches++;
            end
            else
            begin
                oldest_y = y_expected.pop_front();
                if (m_tdata[Y_BITS-1:0] !== oldest_y.y_sum)
                begin
                    $error("y_sum: expected %0d actual %0d",
                           $signed(oldest_y.y_sum), $signed(m_tdata[Y_BITS-1:0]));
                    mismatches++;
                end
                if (m_tlast !== oldest_y.end_of_signal)
                begin
                    $error("end_of_signal: expected %0b actual %0b",
                           oldest_y.end_of_signal, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // block is idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || y_expected.size() != 0);
    endtask

    // APB write then read-back of kernel_length; only called while idle
    task automatic write_kernel_length(input logic [KLEN_W-1:0] len);
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= KLEN_ADDR;
        pwdata  <= APB_DW'(len);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        klen_model = len;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;

        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DW'(len))
        begin
            $error("kernel_length readback: expected %0d actual %0d", len, prdata);
            cfg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic void push_req(logic [SAMPLE_BITS-1:0] s,
                                     logic [SAMPLE_BITS-1:0] r, logic last);
        conv_req_t req;

        req.s_sample = s;
        req.r_sample = r;
        req.last     = last;
        pending_reqs.push_back(req);
    endfunction

    // full-range samples, with extremes mixed in when wild is set
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(bit wild);
        if (wild && $urandom_range(0, 2) == 0)
            case ($urandom_range(0, 4))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                default: return 16'h0001;
            endcase
        return SAMPLE_BITS'($urandom_range(0, 65535));
    endfunction

    // one whole signal, last set on the final request
    function automatic void queue_signal(int len, bit wild);
        for (int i = 0; i < len; i++)
            push_req(pick_sample(wild), pick_sample(wild), i == len - 1);
    endfunction

    function automatic logic [KLEN_W-1:0] pick_kernel_length();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 15)
            return KLEN_W'(1);
        else if (roll < 25)
            return KLEN_W'(MAX_TAPS);
        else if (roll < 32)
            return KLEN_W'($urandom_range(MAX_TAPS + 1, 2047));
        else if (roll < 40)
            return KLEN_W'($urandom_range(25, 200));
        return KLEN_W'($urandom_range(2, 24));
    endfunction

    // mostly short signals keep the MAC walk short
    function automatic int pick_signal_len();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 55)
            return $urandom_range(1, 8);
        else if (roll < 90)
            return $urandom_range(9, 30);
        return $urandom_range(31, 64);
    endfunction

    // ------------------------------------------------------------------------
    // Run timeout
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int random_sent;
        int before_phase;
        int n_sig;

        random_sent = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // -- directed --
        // kernel length left at its reset value; product extremes
        push_req(16'h7FFF, 16'h7FFF, 1'b0);
        push_req(16'h8000, 16'h8000, 1'b0);
        push_req(16'h8000, 16'h7FFF, 1'b0);
        push_req(16'h0000, 16'hFFFF, 1'b1);
        // one-request signal, largest positive product
        push_req(16'h8000, 16'h8000, 1'b1);

        // zero length: nothing summed
        write_kernel_length('0);
        push_req(16'h04D2, 16'hFFFB, 1'b0);
        push_req(16'hFFFF, 16'h0007, 1'b1);

        // above MAX_TAPS: clamped
        write_kernel_length(11'h7FF);
        push_req(16'h7FFF, 16'h8000, 1'b0);
        push_req(16'h8000, 16'h7FFF, 1'b1);

        // single tap: second r ignored
        write_kernel_length(KLEN_W'(1));
        push_req(16'h4000, 16'h7FFF, 1'b0);
        push_req(16'h8000, 16'h1234, 1'b1);

        // signal longer than the kernel
        write_kernel_length(KLEN_W'(6));
        queue_signal(8, 1'b1);

        // length raised mid-signal: taps 2..3 keep values of the signal above
        write_kernel_length(KLEN_W'(2));
        for (int i = 0; i < 4; i++)
            push_req(pick_sample(1'b1), pick_sample(1'b1), 1'b0);
        write_kernel_length(KLEN_W'(6));
        push_req(pick_sample(1'b0), pick_sample(1'b0), 1'b0);
        push_req(pick_sample(1'b0), pick_sample(1'b0), 1'b1);

        // -- random phases, one kernel length each, always ending on last --
        while (random_sent < RANDOM_REQS)
        begin
            write_kernel_length(pick_kernel_length());
            calm = ($urandom_range(0, 4) == 0);
            before_phase = pending_reqs.size();
            n_sig = $urandom_range(1, 4);
            for (int i = 0; i < n_sig; i++)
                queue_signal(pick_signal_len(), $urandom_range(0, 3) == 0);
            random_sent += pending_reqs.size() - before_phase;
            // first sizeable phase: sink holds off while requests keep coming
            if (!hold_req && pending_reqs.size() >= 20)
                hold_req = 1'b1;
            wait_idle();
        end

        // drain, then a short settle for any stray result
        wait_idle();
        repeat (40) @(posedge clk);
        if (y_expected.size() != 0)
            $error("%0d expected results never arrived", y_expected.size());

        if (mismatches == 0 && cfg_errors == 0 && y_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ccm_pkg.sv
rtl/ccm_ram.sv
rtl/ccm_mac.sv
rtl/ccm_seq.sv
rtl/causal_convolution_mac.sv
rtl/ccm_checker.sv
tb/sv/tb_top.sv
